// ===== hw/rtl/lkvc_pkg.sv =====
package lkvc_pkg;

   localparam int DEF_ENTRIES    = 16;
   localparam int DEF_KEY_BITS   = 16;
   localparam int DEF_VALUE_BITS = 16;

   localparam int          CAP_BITS  = 5;
   localparam logic [4:0]  CAP_RESET = 5'd16;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

endpackage

// ===== hw/rtl/lkvc_entry_ram.sv =====
module lkvc_entry_ram #(
   parameter int DEPTH      = 16,
   parameter int WORD_BITS  = 36,
   parameter int ADDR_BITS  = 4
) (
   input  logic                 clock,
   input  logic                 write_enable,
   input  logic [ADDR_BITS-1:0] write_addr,
   input  logic [WORD_BITS-1:0] write_data,
   input  logic [ADDR_BITS-1:0] read_addr,
   output logic [WORD_BITS-1:0] read_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      read_data_ff <= mem[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
// lru_key_value_cache: fully associative key/value store with true lru replacement.
// request channel (req_): operation (get or put), key and write value, taken at a
// clock edge with req_valid high and req_stall low. one result item per request
// comes out on the rsp_ channel: hit, read value and evicted flag.
// csr_write_enable loads the capacity register (values of zero act as one, values
// above ENTRIES act as ENTRIES); write it only while the block is idle.
// each entry (key, value, recency rank) sits in one word of a single-port-write
// synchronous ram. an item takes one read sweep over all entries to find the key,
// the victim and a free slot, then, for a hit or a put, a read-modify-write sweep
// that ages the ranks and writes the target entry.
// the ram sweeps set the time from accept to the result showing on rsp_valid.
// one item is in work at a time; a new item is taken once the previous result is
// in the output register, even while that result is still stalled.
// if rsp_stall holds a result, the next finished item waits in its last state.
// reset (synchronous) empties the cache, sets capacity to 16 and drops any
// pending result; the ram contents need no clearing since valid bits guard them.
module lru_key_value_cache #(
   parameter int ENTRIES    = lkvc_pkg::DEF_ENTRIES,
   parameter int KEY_BITS   = lkvc_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS = lkvc_pkg::DEF_VALUE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_operation,
   input  logic [KEY_BITS-1:0]             req_key,
   input  logic [VALUE_BITS-1:0]           req_write_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_hit,
   output logic [VALUE_BITS-1:0]           rsp_read_value,
   output logic                            rsp_evicted,
   input  logic                            csr_write_enable,
   input  logic [lkvc_pkg::CAP_BITS-1:0]   csr_write_data
);

   import lkvc_pkg::*;

   localparam int IB   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RB   = IB;
   localparam int OB   = $clog2(ENTRIES + 1);
   localparam int CW   = (OB > CAP_BITS) ? OB : CAP_BITS;
   localparam int WW   = KEY_BITS + VALUE_BITS + RB;
   localparam logic [IB-1:0] LAST = IB'(ENTRIES - 1);

   // fsm
   state_type state_ff, state_in;

   // sweep control
   logic [IB-1:0] cnt_ff, cnt_in;
   logic          issue_ff, issue_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [IB-1:0] rd_idx_ff, rd_idx_in;

   // captured request
   logic                  op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] wval_ff, wval_in;

   // scan results
   logic                  found_ff, found_in;
   logic [IB-1:0]         found_idx_ff, found_idx_in;
   logic [RB-1:0]         found_rank_ff, found_rank_in;
   logic [VALUE_BITS-1:0] found_val_ff, found_val_in;
   logic                  vict_ff, vict_in;
   logic [IB-1:0]         vict_idx_ff, vict_idx_in;
   logic [RB-1:0]         vict_rank_ff, vict_rank_in;
   logic                  free_ff, free_in;
   logic [IB-1:0]         free_idx_ff, free_idx_in;

   // update plan
   logic [IB-1:0]         tgt_idx_ff, tgt_idx_in;
   logic [RB-1:0]         limit_ff, limit_in;
   logic                  age_all_ff, age_all_in;
   logic [VALUE_BITS-1:0] new_val_ff, new_val_in;

   // result waiting for the output register
   logic                  res_hit_ff, res_hit_in;
   logic [VALUE_BITS-1:0] res_rval_ff, res_rval_in;
   logic                  res_evict_ff, res_evict_in;

   // architectural state outside the ram
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [OB-1:0]         occ_ff, occ_in;
   logic [CAP_BITS-1:0]   cap_ff, cap_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [VALUE_BITS-1:0] rsp_rval_ff, rsp_rval_in;
   logic                  rsp_evict_ff, rsp_evict_in;

   // fsm outputs
   logic accept;
   logic begin_sweep;
   logic scan_en;
   logic decide_en;
   logic upd_en;
   logic load_rsp;
   logic sweep_last;

   // ram port
   logic          ram_we;
   logic [IB-1:0] ram_waddr;
   logic [WW-1:0] ram_wdata;
   logic [WW-1:0] ram_rdata;

   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   logic [RB-1:0]         rd_rank;

   // decision terms
   logic          is_put;
   logic          do_insert;
   logic          do_evict;
   logic          do_update;
   logic [CW-1:0] cap_ext;
   logic [CW-1:0] eff_cap;

   assign rd_key  = ram_rdata[WW-1 -: KEY_BITS];
   assign rd_val  = ram_rdata[RB +: VALUE_BITS];
   assign rd_rank = ram_rdata[RB-1:0];

   assign sweep_last = rd_vld_ff && (rd_idx_ff == LAST);

   assign cap_ext = CW'(cap_ff);
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CW'(1);
      end else if (cap_ext > CW'(ENTRIES)) begin
         eff_cap = CW'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign is_put    = (op_ff == OP_PUT);
   assign do_insert = !found_ff && is_put && (CW'(occ_ff) < eff_cap);
   assign do_evict  = !found_ff && is_put && !do_insert;
   assign do_update = found_ff || is_put;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sweep_last) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = do_update ? ST_UPDATE : ST_FINISH;
         end
         ST_UPDATE: begin
            if (sweep_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // fsm outputs
   always_comb begin
      req_stall = 1'b1;
      accept    = 1'b0;
      scan_en   = 1'b0;
      decide_en = 1'b0;
      upd_en    = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
         end
         ST_SCAN: begin
            scan_en = 1'b1;
         end
         ST_DECIDE: begin
            decide_en = 1'b1;
         end
         ST_UPDATE: begin
            upd_en = 1'b1;
         end
         ST_FINISH: begin
            load_rsp = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign begin_sweep = accept || (decide_en && do_update);

   // datapath next values
   always_comb begin
      cnt_in        = cnt_ff;
      issue_in      = issue_ff;
      rd_vld_in     = issue_ff;
      rd_idx_in     = cnt_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      wval_in       = wval_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_rank_in = found_rank_ff;
      found_val_in  = found_val_ff;
      vict_in       = vict_ff;
      vict_idx_in   = vict_idx_ff;
      vict_rank_in  = vict_rank_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      tgt_idx_in    = tgt_idx_ff;
      limit_in      = limit_ff;
      age_all_in    = age_all_ff;
      new_val_in    = new_val_ff;
      res_hit_in    = res_hit_ff;
      res_rval_in   = res_rval_ff;
      res_evict_in  = res_evict_ff;
      valid_in      = valid_ff;
      occ_in        = occ_ff;
      cap_in        = csr_write_enable ? csr_write_data : cap_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_hit_in    = rsp_hit_ff;
      rsp_rval_in   = rsp_rval_ff;
      rsp_evict_in  = rsp_evict_ff;
      ram_we        = 1'b0;
      ram_waddr     = rd_idx_ff;
      ram_wdata     = ram_rdata;

      // read address sequencer, shared by both sweeps
      if (begin_sweep) begin
         cnt_in   = '0;
         issue_in = 1'b1;
      end else if (issue_ff) begin
         if (cnt_ff == LAST) begin
            issue_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + IB'(1);
         end
      end

      if (accept) begin
         op_in    = req_operation;
         key_in   = req_key;
         wval_in  = req_write_value;
         found_in = 1'b0;
         vict_in  = 1'b0;
         free_in  = 1'b0;
      end

      if (scan_en && rd_vld_ff) begin
         if (valid_ff[rd_idx_ff]) begin
            if (!found_ff && rd_key == key_ff) begin
               found_in      = 1'b1;
               found_idx_in  = rd_idx_ff;
               found_rank_in = rd_rank;
               found_val_in  = rd_val;
            end
            if (!vict_ff || rd_rank > vict_rank_ff) begin
               vict_in      = 1'b1;
               vict_idx_in  = rd_idx_ff;
               vict_rank_in = rd_rank;
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_idx_in = rd_idx_ff;
         end
      end

      if (decide_en) begin
         age_all_in   = do_insert;
         limit_in     = found_ff ? found_rank_ff : vict_rank_ff;
         res_hit_in   = found_ff;
         res_evict_in = do_evict;
         res_rval_in  = (found_ff && !is_put) ? found_val_ff : '0;
         new_val_in   = (found_ff && !is_put) ? found_val_ff : wval_ff;
         if (found_ff) begin
            tgt_idx_in = found_idx_ff;
         end else if (do_insert) begin
            tgt_idx_in = free_idx_ff;
         end else begin
            tgt_idx_in = vict_idx_ff;
         end
         if (do_insert) begin
            valid_in[free_idx_ff] = 1'b1;
            occ_in                = occ_ff + OB'(1);
         end
      end

      // rank aging: entries younger than the limit move back by one (all live ones on an insert)
      if (upd_en && rd_vld_ff) begin
         if (rd_idx_ff == tgt_idx_ff) begin
            ram_we    = 1'b1;
            ram_wdata = {key_ff, new_val_ff, {RB{1'b0}}};
         end else if (valid_ff[rd_idx_ff] && (age_all_ff || rd_rank < limit_ff)) begin
            ram_we    = 1'b1;
            ram_wdata = {rd_key, rd_val, rd_rank + RB'(1)};
         end
      end

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = res_hit_ff;
         rsp_rval_in  = res_rval_ff;
         rsp_evict_in = res_evict_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= rd_vld_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      rd_idx_ff     <= rd_idx_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      wval_ff       <= wval_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      found_rank_ff <= found_rank_in;
      found_val_ff  <= found_val_in;
      vict_ff       <= vict_in;
      vict_idx_ff   <= vict_idx_in;
      vict_rank_ff  <= vict_rank_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      tgt_idx_ff    <= tgt_idx_in;
      limit_ff      <= limit_in;
      age_all_ff    <= age_all_in;
      new_val_ff    <= new_val_in;
      res_hit_ff    <= res_hit_in;
      res_rval_ff   <= res_rval_in;
      res_evict_ff  <= res_evict_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_rval_ff   <= rsp_rval_in;
      rsp_evict_ff  <= rsp_evict_in;
   end

   lkvc_entry_ram #(
      .DEPTH     (ENTRIES),
      .WORD_BITS (WW),
      .ADDR_BITS (IB)
   ) u_entry_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (ram_waddr),
      .write_data   (ram_wdata),
      .read_addr    (cnt_ff),
      .read_data    (ram_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_rval_ff;
   assign rsp_evicted    = rsp_evict_ff;

endmodule

// ===== bench/tb_lru_key_value_cache.sv =====
module tb_lru_key_value_cache;
   timeunit 1ns;
   timeprecision 1ps;

   import lkvc_pkg::*;

   localparam int ENTRIES         = DEF_ENTRIES;
   localparam int KEY_BITS        = DEF_KEY_BITS;
   localparam int VALUE_BITS      = DEF_VALUE_BITS;
   localparam real CLOCK_PERIOD   = 12.0;
   localparam int LATENCY         = 2 * ENTRIES + 5;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int ITEMS_PER_PHASE = 114;
   localparam int PHASES          = 9;
   localparam int POOL_DEPTH      = 24;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic                  hit;
      logic [VALUE_BITS-1:0] read_value;
      logic                  evicted;
   } cache_result_type;

   typedef struct packed {
      logic                  is_cfg;
      logic [CAP_BITS-1:0]   cfg_value;
      logic                  op;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] wval;
      logic                  typed;
      cache_result_type      want;
   } step_type;

   localparam cache_result_type NO_HIT  = '{1'b0, 16'h0000, 1'b0};
   localparam cache_result_type PUT_HIT = '{1'b1, 16'h0000, 1'b0};
   localparam cache_result_type EVICT   = '{1'b0, 16'h0000, 1'b1};

   // typed rows walk the lru order by hand: capacity drops to zero (acts as one)
   // while two entries are live, so new keys evict the oldest one
   localparam int DIRECTED_ROWS = 27;
   localparam step_type DIRECTED_STEPS [DIRECTED_ROWS] = '{
      '{1'b0, 5'd0,  OP_GET, 16'h0000, 16'h0000, 1'b1, NO_HIT},
      '{1'b0, 5'd0,  OP_GET, 16'hFFFF, 16'hFFFF, 1'b1, NO_HIT},
      '{1'b0, 5'd0,  OP_PUT, 16'h0000, 16'hFFFF, 1'b1, NO_HIT},
      '{1'b0, 5'd0,  OP_GET, 16'h0000, 16'h0000, 1'b1, '{1'b1, 16'hFFFF, 1'b0}},
      '{1'b0, 5'd0,  OP_PUT, 16'hFFFF, 16'h0000, 1'b1, NO_HIT},
      '{1'b0, 5'd0,  OP_PUT, 16'h0000, 16'h1234, 1'b1, PUT_HIT},
      '{1'b0, 5'd0,  OP_GET, 16'h0000, 16'hFFFF, 1'b1, '{1'b1, 16'h1234, 1'b0}},
      '{1'b0, 5'd0,  OP_GET, 16'hFFFF, 16'h0000, 1'b1, '{1'b1, 16'h0000, 1'b0}},
      '{1'b1, 5'd0,  OP_GET, 16'h0000, 16'h0000, 1'b0, NO_HIT},
      '{1'b0, 5'd0,  OP_PUT, 16'h00FF, 16'hAAAA, 1'b1, EVICT},
      '{1'b0, 5'd0,  OP_GET, 16'h0000, 16'h0000, 1'b1, NO_HIT},
      '{1'b0, 5'd0,  OP_GET, 16'h00FF, 16'h0000, 1'b1, '{1'b1, 16'hAAAA, 1'b0}},
      '{1'b0, 5'd0,  OP_PUT, 16'h5555, 16'h5555, 1'b1, EVICT},
      '{1'b0, 5'd0,  OP_GET, 16'hFFFF, 16'h0000, 1'b1, NO_HIT},
      '{1'b1, 5'd31, OP_GET, 16'h0000, 16'h0000, 1'b0, NO_HIT},
      '{1'b0, 5'd0,  OP_PUT, 16'h8000, 16'h0001, 1'b0, NO_HIT},
      '{1'b0, 5'd0,  OP_PUT, 16'h0001, 16'h8000, 1'b0, NO_HIT},
      '{1'b0, 5'd0,  OP_GET, 16'h8000, 16'h0000, 1'b0, NO_HIT},
      '{1'b0, 5'd0,  OP_GET, 16'h5555, 16'h0000, 1'b0, NO_HIT},
      '{1'b1, 5'd1,  OP_GET, 16'h0000, 16'h0000, 1'b0, NO_HIT},
      '{1'b0, 5'd0,  OP_PUT, 16'h7FFF, 16'h7FFF, 1'b0, NO_HIT},
      '{1'b0, 5'd0,  OP_GET, 16'h00FF, 16'h0000, 1'b0, NO_HIT},
      '{1'b1, 5'd16, OP_GET, 16'h0000, 16'h0000, 1'b0, NO_HIT},
      '{1'b0, 5'd0,  OP_PUT, 16'h1111, 16'h2222, 1'b0, NO_HIT},
      '{1'b0, 5'd0,  OP_GET, 16'h1111, 16'h0000, 1'b0, NO_HIT},
      '{1'b0, 5'd0,  OP_PUT, 16'h1111, 16'h3333, 1'b0, NO_HIT},
      '{1'b0, 5'd0,  OP_GET, 16'h1111, 16'h0000, 1'b0, NO_HIT}
   };

   localparam logic [CAP_BITS-1:0] PHASE_CAPS [8] = '{
      5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd9, 5'd2, 5'd16
   };

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_operation = OP_GET;
   logic [KEY_BITS-1:0]         req_key = '0;
   logic [VALUE_BITS-1:0]       req_write_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_hit;
   logic [VALUE_BITS-1:0]       rsp_read_value;
   logic                        rsp_evicted;
   logic                        csr_write_enable = 1'b0;
   logic [CAP_BITS-1:0]         csr_write_data = '0;

   // cache model state
   logic                        line_valid [ENTRIES];
   logic [KEY_BITS-1:0]         line_key   [ENTRIES];
   logic [VALUE_BITS-1:0]       line_value [ENTRIES];
   int unsigned                 line_age   [ENTRIES];
   int unsigned                 lines_used;
   logic [CAP_BITS-1:0]         model_capacity;

   cache_result_type            expected_results [$];
   logic                        drive_typed = 1'b0;
   cache_result_type            drive_want = '0;
   logic                        sender_idle = 1'b1;
   logic                        receiver_idle = 1'b1;
   int                          stall_left = 0;
   int                          idle_cycles = 0;
   int                          mismatch_count = 0;
   int                          items_sent = 0;
   int                          puts_sent = 0;
   int                          hits_seen = 0;
   int                          evictions_seen = 0;
   int                          cfg_writes = 0;

   lru_key_value_cache DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_key          (req_key),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_read_value   (rsp_read_value),
      .rsp_evicted      (rsp_evicted),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2.0) clock = ~clock;

   function automatic void clear_cache_model();
      for (int i = 0; i < ENTRIES; i++) begin
         line_valid[i] = 1'b0;
         line_key[i] = '0;
         line_value[i] = '0;
         line_age[i] = 0;
      end
      lines_used = 0;
      model_capacity = CAP_RESET;
   endfunction

   // live entries younger than limit age by one, slot becomes the newest
   function automatic void make_newest(int slot, int unsigned limit);
      for (int i = 0; i < ENTRIES; i++)
         if (i != slot && line_valid[i] && line_age[i] < limit) line_age[i]++;
      line_age[slot] = 0;
   endfunction

   function automatic cache_result_type cache_access(logic op, logic [KEY_BITS-1:0] key,
                                                     logic [VALUE_BITS-1:0] wval);
      cache_result_type res;
      int found;
      int slot;
      int victim;
      int room;
      int unsigned oldest;
      res = '0;
      found = -1;
      slot = -1;
      victim = -1;
      oldest = 0;
      for (int i = 0; i < ENTRIES; i++)
         if (found < 0 && line_valid[i] && line_key[i] == key) found = i;
      if (found >= 0) begin
         res.hit = 1'b1;
         if (op == OP_PUT) line_value[found] = wval;
         else res.read_value = line_value[found];
         make_newest(found, line_age[found]);
      end else if (op == OP_PUT) begin
         room = (model_capacity == 0) ? 1 :
                (model_capacity > ENTRIES) ? ENTRIES : int'(model_capacity);
         if (lines_used < room)
            for (int i = 0; i < ENTRIES; i++)
               if (slot < 0 && !line_valid[i]) slot = i;
         if (slot >= 0) begin
            line_valid[slot] = 1'b1;
            line_key[slot] = key;
            line_value[slot] = wval;
            lines_used++;
            make_newest(slot, ENTRIES + 1);
         end else begin
            for (int i = 0; i < ENTRIES; i++)
               if (line_valid[i] && (victim < 0 || line_age[i] > oldest)) begin
                  victim = i;
                  oldest = line_age[i];
               end
            if (victim >= 0) begin
               line_key[victim] = key;
               line_value[victim] = wval;
               make_newest(victim, oldest);
               res.evicted = 1'b1;
            end
         end
      end
      return res;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_result(input string note, input cache_result_type want,
                                input cache_result_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%s: expected hit=%0b value=%h evicted=%0b, got hit=%0b value=%h evicted=%0b",
                  note, want.hit, want.read_value, want.evicted,
                  got.hit, got.read_value, got.evicted);
   endtask

   always @(negedge clock) begin
      if (stall_left == 0 && receiver_idle && $urandom_range(0, 99) < 15)
         stall_left = idle_length();
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
   end

   // scoreboard: results are checked before the same edge's request is predicted
   always @(posedge clock) begin
      cache_result_type got;
      cache_result_type want;
      if (reset) begin
         clear_cache_model();
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_hit, rsp_read_value, rsp_evicted};
            if (got.hit === 1'b1) hits_seen++;
            if (got.evicted === 1'b1) evictions_seen++;
            if (expected_results.size() == 0) begin
               report_result("result with nothing outstanding", '0, got);
            end else begin
               want = expected_results.pop_front();
               if (got.hit !== want.hit || got.read_value !== want.read_value ||
                   got.evicted !== want.evicted)
                  report_result("result mismatch", want, got);
            end
         end
         if (csr_write_enable) model_capacity = csr_write_data;
         if (req_valid && !req_stall) begin
            want = cache_access(req_operation, req_key, req_write_value);
            if (drive_typed) want = drive_want;
            expected_results.push_back(want);
            items_sent++;
            if (req_operation == OP_PUT) puts_sent++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                  idle_cycles, expected_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // entered and left at a falling edge; valid stays high into the next item
   task automatic send_req(input logic op, input logic [KEY_BITS-1:0] key,
                           input logic [VALUE_BITS-1:0] wval, input logic typed,
                           input cache_result_type want);
      int gap;
      gap = (sender_idle && $urandom_range(0, 99) < 30) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = op;
      req_key = key;
      req_write_value = wval;
      drive_typed = typed;
      drive_want = want;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] value);
      drain_results();
      repeat (3) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      cfg_writes++;
   endtask

   initial begin
      logic [KEY_BITS-1:0] key_pool [POOL_DEPTH];
      logic [KEY_BITS-1:0] key;
      int pool_size;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (DIRECTED_STEPS[r].is_cfg)
            write_capacity(DIRECTED_STEPS[r].cfg_value);
         else
            send_req(DIRECTED_STEPS[r].op, DIRECTED_STEPS[r].key, DIRECTED_STEPS[r].wval,
                     DIRECTED_STEPS[r].typed, DIRECTED_STEPS[r].want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         write_capacity(ph < 8 ? PHASE_CAPS[ph] : CAP_BITS'($urandom_range(0, 31)));
         sender_idle = (ph % 3) != 1;
         receiver_idle = (ph % 4) != 2;
         pool_size = $urandom_range(1, POOL_DEPTH);
         for (int k = 0; k < POOL_DEPTH; k++) key_pool[k] = KEY_BITS'($urandom);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n == ITEMS_PER_PHASE / 2) drain_results();
            // mostly keys from a small working set so gets hit and puts evict
            if ($urandom_range(0, 9) == 0) key = KEY_BITS'($urandom);
            else key = key_pool[$urandom_range(0, pool_size - 1)];
            send_req(1'($urandom_range(0, 1)), key, VALUE_BITS'($urandom), 1'b0, '0);
         end
      end

      drain_results();
      repeat (LATENCY + 3) @(negedge clock);
      $display("ran %0d requests (%0d puts) under %0d capacity settings",
               items_sent, puts_sent, cfg_writes);
      $display("results showed %0d hits and %0d evictions, %0d mismatches",
               hits_seen, evictions_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_entry_ram.sv
hw/rtl/lru_key_value_cache.sv
bench/tb_lru_key_value_cache.sv
